[rtl/core/fsib_pkg.sv]
// ----------------------------------------------------------------------------
// fsib_pkg
// Shared types, sizes and codes of the flash sector image buffer.
// ----------------------------------------------------------------------------
package fsib_pkg;

    localparam int MAX_SECTORS      = 8;
    localparam int MAX_SECTOR_BYTES = 1024;
    localparam int MAX_SEGMENT      = 64;

    localparam int SLOT_W   = 3;
    localparam int CNT_W    = 4;
    localparam int BOFF_W   = 10;
    localparam int OFF_W    = 11;
    localparam int SEG_W    = 7;
    localparam int ADDR_W   = 32;
    localparam int STORE_AW = SLOT_W + BOFF_W;
    localparam int STORE_DEPTH = MAX_SECTORS * MAX_SECTOR_BYTES;
    localparam int CFG_W    = 11;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
    localparam logic [7:0]  ERASED   = 8'hFF;
    localparam logic [7:0]  DATA_REC = 8'h00;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_FETCH = 2'd1,
        MODE_CRC   = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_INDEX = 2'd3
    } t_status;

    typedef enum logic {
        CFG_SECTOR_SIZE = 1'b0,
        CFG_SEGMENT_MAX = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        EMIT_STATUS = 2'd0,
        EMIT_CRC    = 2'd1,
        EMIT_BYTE   = 2'd2
    } t_emit_kind;

    typedef struct packed {
        t_mode        mode;
        logic [7:0]   record_type;
        logic [31:0]  write_address;
        logic [7:0]   write_byte;
        logic [2:0]   slot_index;
        logic [10:0]  start_offset;
    } t_in_item;

    typedef struct packed {
        logic [1:0]   status;
        logic [7:0]   out_byte;
        logic [31:0]  byte_address;
        logic [6:0]   segment_length;
        logic [10:0]  next_offset;
        logic [31:0]  sector_crc;
        logic         last;
    } t_out_item;

    typedef struct packed {
        logic       latch;
        logic       div_step;
        logic       calc_base;
        logic       lookup;
        logic       alloc;
        logic       erase_step;
        logic       store;
        logic       clear;
        logic       crc_init;
        logic       crc_step;
        logic       scan_adv;
        logic       ram_rd;
        logic       seg_setup;
        logic       seg_setup2;
        logic       emit;
        t_emit_kind emit_kind;
        t_status    emit_status;
    } t_dp_cmd;

    typedef struct packed {
        t_mode            mode;
        logic             type_data;
        logic             div_last;
        logic             found;
        logic             full;
        logic             bad_idx;
        logic             erase_last;
        logic             off_ge_size;
        logic             rd_valid;
        logic             out_free;
        logic             last_byte;
        logic [CNT_W-1:0] count;
    } t_dp_sts;

endpackage

[rtl/core/fsib_in_if.sv]
// ----------------------------------------------------------------------------
// fsib_in_if
// Request channel: valid, ready and one request item.
// ----------------------------------------------------------------------------
interface fsib_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  record_type;
    logic [31:0] write_address;
    logic [7:0]  write_byte;
    logic [2:0]  slot_index;
    logic [10:0] start_offset;

    modport source (output valid, mode, record_type, write_address, write_byte,
                    slot_index, start_offset, input ready);
    modport sink (input valid, mode, record_type, write_address, write_byte,
                  slot_index, start_offset, output ready);
endinterface

[rtl/core/fsib_out_if.sv]
// ----------------------------------------------------------------------------
// fsib_out_if
// Response channel: valid, ready and one response item.
// ----------------------------------------------------------------------------
interface fsib_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  out_byte;
    logic [31:0] byte_address;
    logic [6:0]  segment_length;
    logic [10:0] next_offset;
    logic [31:0] sector_crc;
    logic        last;

    modport source (output valid, status, out_byte, byte_address, segment_length,
                    next_offset, sector_crc, last, input ready);
    modport sink (input valid, status, out_byte, byte_address, segment_length,
                  next_offset, sector_crc, last, output ready);
endinterface

[rtl/core/fsib_ram.sv]
// ----------------------------------------------------------------------------
// fsib_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fsib_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 8192,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/fsib_dp.sv]
// ----------------------------------------------------------------------------
// fsib_dp
// Datapath: configuration, slot table, remainder divider, sector store,
// CRC engine and the response register.
// ----------------------------------------------------------------------------
module fsib_dp import fsib_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  t_in_item         i_item,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    output t_out_item        o_out,
    output logic             o_out_valid,
    input  logic             i_out_ready
);
    logic [OFF_W-1:0]  r_size_cfg;
    logic [SEG_W-1:0]  r_seg_cfg;
    logic [CNT_W-1:0]  r_count;
    logic [ADDR_W-1:0] r_base [MAX_SECTORS];

    t_mode             r_mode;
    logic [7:0]        r_type;
    logic [ADDR_W-1:0] r_addr;
    logic [7:0]        r_byte;
    logic [SLOT_W-1:0] r_idx;
    logic [OFF_W-1:0]  r_off;

    logic [OFF_W-1:0]  r_rem;
    logic [ADDR_W-1:0] r_dvd;
    logic [4:0]        r_dcnt;
    logic [ADDR_W-1:0] r_wbase;
    logic [BOFF_W-1:0] r_woff;
    logic              r_found;
    logic [SLOT_W-1:0] r_slot;
    logic [BOFF_W-1:0] r_ecnt;
    logic [31:0]       r_crc;
    logic [SEG_W-1:0]  r_len;
    logic [SEG_W-1:0]  r_bcnt;
    logic [OFF_W-1:0]  r_nxt;
    logic [ADDR_W-1:0] r_first;

    logic              r_o_valid;
    t_out_item         r_out;
    t_out_item         n_out;

    logic [OFF_W-1:0]  w_size;
    logic [SEG_W-1:0]  w_seg;
    logic [OFF_W:0]    w_trial;
    logic [OFF_W-1:0]  w_rem_next;
    logic              w_hit;
    logic [SLOT_W-1:0] w_hit_slot;
    logic [31:0]       w_crc_next;
    logic [OFF_W-1:0]  w_room;
    logic              w_last_byte;
    logic              w_ram_we;
    logic [STORE_AW-1:0] w_waddr;
    logic [8:0]        w_wdata;
    logic [8:0]        w_rdata;

    // Register values out of range saturate to the supported limits.
    always_comb begin
        if (r_size_cfg == '0) begin
            w_size = OFF_W'(1);
        end else if (r_size_cfg > OFF_W'(MAX_SECTOR_BYTES)) begin
            w_size = OFF_W'(MAX_SECTOR_BYTES);
        end else begin
            w_size = r_size_cfg;
        end
        if (r_seg_cfg == '0) begin
            w_seg = SEG_W'(1);
        end else if (r_seg_cfg > SEG_W'(MAX_SEGMENT)) begin
            w_seg = SEG_W'(MAX_SEGMENT);
        end else begin
            w_seg = r_seg_cfg;
        end
    end

    // One restoring step of address modulo sector size.
    always_comb begin
        w_trial = {r_rem, r_dvd[ADDR_W-1]};
        if (w_trial >= {1'b0, w_size}) begin
            w_trial = w_trial - {1'b0, w_size};
        end
        w_rem_next = w_trial[OFF_W-1:0];
    end

    always_comb begin
        w_hit      = 1'b0;
        w_hit_slot = '0;
        for (int i = MAX_SECTORS - 1; i >= 0; i--) begin
            if ((CNT_W'(i) < r_count) && (r_base[i] == r_wbase)) begin
                w_hit      = 1'b1;
                w_hit_slot = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        w_crc_next = r_crc ^ {24'b0, w_rdata[7:0]};
        for (int b = 0; b < 8; b++) begin
            w_crc_next = w_crc_next[0] ? ((w_crc_next >> 1) ^ CRC_POLY)
                                       : (w_crc_next >> 1);
        end
    end

    assign w_room      = w_size - r_off;
    assign w_last_byte = (r_bcnt + SEG_W'(1)) == r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_cfg <= OFF_W'(MAX_SECTOR_BYTES);
            r_seg_cfg  <= SEG_W'(MAX_SEGMENT);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SECTOR_SIZE: r_size_cfg <= i_cfg_data[OFF_W-1:0];
                CFG_SEGMENT_MAX: r_seg_cfg  <= i_cfg_data[SEG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.alloc) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc) begin
            r_base[r_count[SLOT_W-1:0]] <= r_wbase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode <= i_item.mode;
            r_type <= i_item.record_type;
            r_addr <= i_item.write_address;
            r_byte <= i_item.write_byte;
            r_idx  <= i_item.slot_index;
            r_off  <= i_item.start_offset;
            r_rem  <= '0;
            r_dvd  <= i_item.write_address;
            r_dcnt <= '0;
        end else begin
            if (i_cmd.div_step) begin
                r_rem  <= w_rem_next;
                r_dvd  <= {r_dvd[ADDR_W-2:0], 1'b0};
                r_dcnt <= r_dcnt + 5'd1;
            end
            if (i_cmd.crc_init) begin
                r_off <= '0;
            end else if (i_cmd.crc_step || i_cmd.scan_adv ||
                         (i_cmd.emit && i_cmd.emit_kind == EMIT_BYTE)) begin
                r_off <= r_off + OFF_W'(1);
            end
        end
        if (i_cmd.calc_base) begin
            r_wbase <= r_addr - ADDR_W'(r_rem);
            r_woff  <= r_rem[BOFF_W-1:0];
        end
        if (i_cmd.lookup) begin
            r_found <= w_hit;
            r_slot  <= w_hit_slot;
        end else if (i_cmd.alloc) begin
            r_slot <= r_count[SLOT_W-1:0];
        end
        if (i_cmd.alloc) begin
            r_ecnt <= '0;
        end else if (i_cmd.erase_step) begin
            r_ecnt <= r_ecnt + BOFF_W'(1);
        end
        if (i_cmd.crc_init) begin
            r_crc <= CRC_INIT;
        end else if (i_cmd.crc_step) begin
            r_crc <= w_crc_next;
        end
        if (i_cmd.seg_setup) begin
            r_len <= (OFF_W'(w_seg) > w_room) ? w_room[SEG_W-1:0] : w_seg;
        end
        if (i_cmd.seg_setup2) begin
            r_nxt   <= r_off + OFF_W'(r_len);
            r_first <= r_base[r_idx] + ADDR_W'(r_off);
            r_bcnt  <= '0;
        end else if (i_cmd.emit && i_cmd.emit_kind == EMIT_BYTE) begin
            r_bcnt <= r_bcnt + SEG_W'(1);
        end
    end

    assign w_ram_we = i_cmd.erase_step | i_cmd.store;
    assign w_waddr  = i_cmd.erase_step ? {r_slot, r_ecnt} : {r_slot, r_woff};
    assign w_wdata  = i_cmd.erase_step ? {1'b0, ERASED} : {1'b1, r_byte};

    fsib_ram #(
        .WIDTH(9),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (i_cmd.ram_rd),
        .i_raddr({r_idx, r_off[BOFF_W-1:0]}),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_comb begin
        n_out      = '0;
        n_out.last = 1'b1;
        case (i_cmd.emit_kind)
            EMIT_STATUS: begin
                n_out.status = i_cmd.emit_status;
                if (i_cmd.emit_status == ST_EXHAUSTED) begin
                    n_out.next_offset = w_size;
                end
            end
            EMIT_CRC: begin
                n_out.sector_crc = r_crc ^ CRC_INIT;
            end
            EMIT_BYTE: begin
                n_out.out_byte       = w_rdata[7:0];
                n_out.byte_address   = r_first;
                n_out.segment_length = r_len;
                n_out.next_offset    = r_nxt;
                n_out.last           = w_last_byte;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_o_valid;

    always_comb begin
        o_sts             = '0;
        o_sts.mode        = r_mode;
        o_sts.type_data   = (r_type == DATA_REC);
        o_sts.div_last    = (r_dcnt == 5'd31);
        o_sts.found       = r_found;
        o_sts.full        = (r_count >= CNT_W'(MAX_SECTORS));
        o_sts.bad_idx     = ({1'b0, r_idx} >= r_count);
        o_sts.erase_last  = &r_ecnt;
        o_sts.off_ge_size = (r_off >= w_size);
        o_sts.rd_valid    = w_rdata[8];
        o_sts.out_free    = !r_o_valid;
        o_sts.last_byte   = w_last_byte;
        o_sts.count       = r_count;
    end
endmodule

[rtl/core/fsib_ctrl.sv]
// ----------------------------------------------------------------------------
// fsib_ctrl
// Controller: sequences each request through the datapath.
// ----------------------------------------------------------------------------
module fsib_ctrl import fsib_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);
    typedef enum logic [17:0] {
        S_IDLE      = 18'h00001,
        S_DISPATCH  = 18'h00002,
        S_DIV       = 18'h00004,
        S_BASE      = 18'h00008,
        S_LOOK      = 18'h00010,
        S_DECIDE    = 18'h00020,
        S_ERASE     = 18'h00040,
        S_STORE     = 18'h00080,
        S_RESP      = 18'h00100,
        S_CRC_CHK   = 18'h00200,
        S_CRC_STEP  = 18'h00400,
        S_CRC_OUT   = 18'h00800,
        S_SCAN_CHK  = 18'h01000,
        S_SCAN_TST  = 18'h02000,
        S_SEG1      = 18'h04000,
        S_SEG2      = 18'h08000,
        S_BYTE_RD   = 18'h10000,
        S_BYTE_EMIT = 18'h20000
    } t_state;

    t_state  r_state, n_state;
    t_status r_stat, n_stat;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_stat  = r_stat;
        o_cmd   = '0;
        o_cmd.emit_kind   = EMIT_STATUS;
        o_cmd.emit_status = r_stat;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_stat = ST_OK;
                case (i_sts.mode)
                    MODE_WRITE: n_state = i_sts.type_data ? S_DIV : S_RESP;
                    MODE_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_RESP;
                    end
                    MODE_CRC: begin
                        if (i_sts.bad_idx) begin
                            n_stat  = ST_BAD_INDEX;
                            n_state = S_RESP;
                        end else begin
                            o_cmd.crc_init = 1'b1;
                            n_state        = S_CRC_CHK;
                        end
                    end
                    default: begin
                        if (i_sts.bad_idx) begin
                            n_stat  = ST_BAD_INDEX;
                            n_state = S_RESP;
                        end else begin
                            n_state = S_SCAN_CHK;
                        end
                    end
                endcase
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_BASE;
                end
            end
            S_BASE: begin
                o_cmd.calc_base = 1'b1;
                n_state         = S_LOOK;
            end
            S_LOOK: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_sts.found) begin
                    n_state = S_STORE;
                end else if (i_sts.full) begin
                    n_stat  = ST_FULL;
                    n_state = S_RESP;
                end else begin
                    o_cmd.alloc = 1'b1;
                    n_state     = S_ERASE;
                end
            end
            S_ERASE: begin
                o_cmd.erase_step = 1'b1;
                if (i_sts.erase_last) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_state     = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_CRC_CHK: begin
                if (i_sts.off_ge_size) begin
                    n_state = S_CRC_OUT;
                end else begin
                    o_cmd.ram_rd = 1'b1;
                    n_state      = S_CRC_STEP;
                end
            end
            S_CRC_STEP: begin
                o_cmd.crc_step = 1'b1;
                n_state        = S_CRC_CHK;
            end
            S_CRC_OUT: begin
                o_cmd.emit_kind = EMIT_CRC;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_SCAN_CHK: begin
                if (i_sts.off_ge_size) begin
                    n_stat  = ST_EXHAUSTED;
                    n_state = S_RESP;
                end else begin
                    o_cmd.ram_rd = 1'b1;
                    n_state      = S_SCAN_TST;
                end
            end
            S_SCAN_TST: begin
                if (i_sts.rd_valid) begin
                    n_state = S_SEG1;
                end else begin
                    o_cmd.scan_adv = 1'b1;
                    n_state        = S_SCAN_CHK;
                end
            end
            S_SEG1: begin
                o_cmd.seg_setup = 1'b1;
                n_state         = S_SEG2;
            end
            S_SEG2: begin
                o_cmd.seg_setup2 = 1'b1;
                n_state          = S_BYTE_RD;
            end
            S_BYTE_RD: begin
                o_cmd.ram_rd = 1'b1;
                n_state      = S_BYTE_EMIT;
            end
            S_BYTE_EMIT: begin
                o_cmd.emit_kind = EMIT_BYTE;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.last_byte ? S_IDLE : S_BYTE_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stat  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_stat  <= n_stat;
        end
    end
endmodule

[rtl/core/flash_sector_image_buffer_top.sv]
// Flash sector image buffer. Requests are taken one at a time. A data byte
// write runs the 32-step remainder divider that aligns the address and,
// when a new slot is opened, erases all 1024 store entries of the slot, one
// entry per cycle. A fetch reads the store once per skipped unwritten byte
// and once per returned byte, and a CRC request reads it once per sector
// byte, both through the single read port of the sector store. Clear and
// non-data writes go straight from dispatch to the response. The response
// register lets a finished response wait while the next request step proceeds.

// ----------------------------------------------------------------------------
// flash_sector_image_buffer_top
// Top level: controller, datapath and channel wiring.
// ----------------------------------------------------------------------------
module flash_sector_image_buffer_top import fsib_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    fsib_in_if.sink          s_in,
    fsib_out_if.source       m_out,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);
    t_dp_cmd   w_cmd;
    t_dp_sts   w_sts;
    t_in_item  w_item;
    t_out_item w_out;
    logic      w_out_valid;
    logic      w_in_ready;

    assign w_item.mode          = t_mode'(s_in.mode);
    assign w_item.record_type   = s_in.record_type;
    assign w_item.write_address = s_in.write_address;
    assign w_item.write_byte    = s_in.write_byte;
    assign w_item.slot_index    = s_in.slot_index;
    assign w_item.start_offset  = s_in.start_offset;
    assign s_in.ready           = w_in_ready;

    fsib_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_in.valid),
        .o_in_ready(w_in_ready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    fsib_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (w_item),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out      (w_out),
        .o_out_valid(w_out_valid),
        .i_out_ready(m_out.ready)
    );

    assign m_out.valid          = w_out_valid;
    assign m_out.status         = w_out.status;
    assign m_out.out_byte       = w_out.out_byte;
    assign m_out.byte_address   = w_out.byte_address;
    assign m_out.segment_length = w_out.segment_length;
    assign m_out.next_offset    = w_out.next_offset;
    assign m_out.sector_crc     = w_out.sector_crc;
    assign m_out.last           = w_out.last;

    // The slot table never holds more sectors than it has entries.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.count <= CNT_W'(MAX_SECTORS))
        else $error("sector count beyond table size");

    // A request is worked on alone: no new one is taken right after another.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in.valid && s_in.ready |=> !s_in.ready)
        else $error("request accepted while another is in progress");

    // Only segment bytes can be non-final, and then the segment has more bytes.
    a_non_last_is_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.last |->
            m_out.status == ST_OK && m_out.segment_length > 7'd1)
        else $error("non-final response that is not a segment byte");
endmodule
